[rtl/eti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eti_pkg: shared types and constants of the eased tween interpolator
// Widths of the value path, opcode and ease mode codes, register indexes,
// sequencer states and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package eti_pkg;

    localparam int VAL_W     = 32;          // signed fixed-point values
    localparam int SPAN_W    = 31;          // duration and elapsed time
    localparam int STEP_W    = 16;          // time step of a tick
    localparam int MODE_W    = 3;           // ease mode register
    localparam int MUL_W     = VAL_W + 1;   // shared multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;   // full product width
    localparam int CFG_IDX_W = 3;

    // item opcodes; the fourth code leaves everything as it is
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RESTART = 2'd1,
        OP_STOP    = 2'd2
    } op_t;

    // ease curves; the remaining codes give unit progress
    typedef enum logic [MODE_W-1:0] {
        EASE_LINEAR     = 3'd0,
        EASE_QUAD_IN    = 3'd1,
        EASE_QUAD_OUT   = 3'd2,
        EASE_QUAD_INOUT = 3'd3
    } ease_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START   = 3'd0,
        REG_END     = 3'd1,
        REG_SPAN    = 3'd2,
        REG_MODE    = 3'd3,
        REG_REVERSE = 3'd4,
        REG_LOOP    = 3'd5
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EASE,
        ST_EASE_FIX,
        ST_FINAL,
        ST_DONE
    } state_t;

    // divider handshake towards the sequencer
    typedef struct packed {
        logic done;
        logic busy;
    } div_status_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
        if ((&v[PROD_W-1:VAL_W-1]) || (~|v[PROD_W-1:VAL_W-1]))
            return v[VAL_W-1:0];
        else if (v[PROD_W-1])
            return {1'b1, {(VAL_W-1){1'b0}}};
        else
            return {1'b0, {(VAL_W-1){1'b1}}};
    endfunction

endpackage
`default_nettype wire

[rtl/eti_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eti_div: progress divider
// Restoring radix-2 divider, one quotient bit per cycle, that forms
// (elapsed << FRAC_BITS) / span and clamps the quotient to signed 32 bits.
// ----------------------------------------------------------------------------
module eti_div
    import eti_pkg::*;
#(
    parameter int FRAC_BITS = 10
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [SPAN_W-1:0]       elapsed,
    input  wire logic [SPAN_W-1:0]       span,
    output div_status_t                  status,
    output logic signed [VAL_W-1:0]      quot
);

    localparam int NUM_W = SPAN_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;    // dividend shifting out, quotient shifting in
    logic [SPAN_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [SPAN_W:0]   rem_shift;
    logic [SPAN_W+1:0] sub;
    logic              ge;

    // one trial subtraction per cycle
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        sub       = {1'b0, rem_shift} - {2'b00, span};
        ge        = ~sub[SPAN_W+1];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {elapsed, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? sub[SPAN_W-1:0] : rem_shift[SPAN_W-1:0];
        end
    end

    // saturate the quotient to the positive 32-bit range
    always_comb
    begin
        if (|num_reg[NUM_W-1:VAL_W-1])
            quot = {1'b0, {(VAL_W-1){1'b1}}};
        else
            quot = {1'b0, num_reg[VAL_W-2:0]};
    end

    assign status.done = done_reg;
    assign status.busy = run_reg;

endmodule
`default_nettype wire

[rtl/eti_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eti_mul: shared signed multiplier
// One registered 33 x 33 signed multiply, loaded on demand by the sequencer
// for the ease curve product and for the final interpolation product.
// ----------------------------------------------------------------------------
module eti_mul
    import eti_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     load,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // product holds until the next load
    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

[rtl/eased_tween_interpolator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eased_tween_interpolator: eased fixed-point tween
// Moves a signed fixed-point value between two endpoints over a configured
// span with linear or quadratic in, out or in-out easing.
//
//  Channel  Dir  Signals                      Contents
//  s_       in   s_tvalid/s_tready/s_tdata    time_step; s_tuser = opcode
//  m_       out  m_tvalid/m_tready/m_tdata    published, present; m_tuser = finished
//  cfg_     in   cfg_we/cfg_index/cfg_data    endpoints, span, mode, flags
//
// A tick with a nonzero span is set by the bit-serial progress divider and
// then runs the ease, shaping and final product steps to its commit step.
// The next item is taken only once the sequencer is back in idle.
// Linear and unit curves skip the shaping step.
// A zero-span tick skips the divider; restart, stop and the idle opcode go
// straight to the commit step. A result still waiting in the output
// register holds the next item in its commit step.
// ----------------------------------------------------------------------------
module eased_tween_interpolator
    import eti_pkg::*;
#(
    parameter int FRAC_BITS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [STEP_W-1:0]     s_tdata,    // [15:0] time_step
    input  wire logic [1:0]            s_tuser,    // [1:0] opcode
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [2*VAL_W-1:0]         m_tdata,    // [31:0] published_value, [63:32] present_value
    output logic                       m_tuser,    // [0] finished
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [VAL_W-1:0]      cfg_data
);

    localparam logic signed [VAL_W-1:0] UNIT_V = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [VAL_W-1:0] HALF_V = UNIT_V >>> 1;

    // configuration registers
    logic signed [VAL_W-1:0] start_value_reg;
    logic signed [VAL_W-1:0] end_value_reg;
    logic [SPAN_W-1:0]       span_time_reg;
    logic [MODE_W-1:0]       ease_mode_reg;
    logic                    reverse_reg;
    logic                    loop_reg;

    // sequencer and tween state
    state_t                  state_reg, state_next;
    logic [SPAN_W-1:0]       elapsed_reg, elapsed_next;
    logic signed [VAL_W-1:0] current_reg, current_next;
    logic [1:0]              op_reg, op_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic signed [VAL_W-1:0] t_reg, t_next;
    logic signed [VAL_W-1:0] e_reg, e_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic signed [VAL_W-1:0] pub_reg, pub_next;
    logic signed [VAL_W-1:0] pres_reg, pres_next;
    logic                    fin_reg, fin_next;

    // shared units
    div_status_t             div_st;
    logic                    div_start;
    logic signed [VAL_W-1:0] div_quot;
    logic                    mul_load;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    // datapath helpers
    logic signed [VAL_W-1:0]  from_val, to_val;
    logic signed [MUL_W-1:0]  diff_val;
    logic signed [VAL_W-1:0]  d_val;
    logic                     t_low;
    logic signed [VAL_W-1:0]  sq_val;
    logic signed [VAL_W-1:0]  dbl_val;
    logic signed [PROD_W-1:0] part_val;
    logic [SPAN_W:0]          step_sum;
    logic [SPAN_W-1:0]        tick_elapsed;
    logic                     in_xfer;

    eti_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .elapsed (elapsed_reg),
        .span    (span_time_reg),
        .status  (div_st),
        .quot    (div_quot)
    );

    eti_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= '0;
            end_value_reg   <= '0;
            span_time_reg   <= '0;
            ease_mode_reg   <= '0;
            reverse_reg     <= 1'b0;
            loop_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START:   start_value_reg <= cfg_data;
                REG_END:     end_value_reg   <= cfg_data;
                REG_SPAN:    span_time_reg   <= cfg_data[SPAN_W-1:0];
                REG_MODE:    ease_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_REVERSE: reverse_reg     <= cfg_data[0];
                REG_LOOP:    loop_reg        <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // endpoints, ease operands and the elapsed time update
    always_comb
    begin
        from_val = reverse_reg ? end_value_reg : start_value_reg;
        to_val   = reverse_reg ? start_value_reg : end_value_reg;
        diff_val = MUL_W'(to_val) - MUL_W'(from_val);
        d_val    = t_reg - UNIT_V;
        t_low    = (t_reg < HALF_V);

        sq_val   = sat_val(mul_prod >>> FRAC_BITS);
        dbl_val  = sat_val(PROD_W'(sq_val) <<< 1);
        part_val = mul_prod >>> FRAC_BITS;

        step_sum = {1'b0, elapsed_reg} + (SPAN_W + 1)'(step_reg);
        if (elapsed_reg == span_time_reg)
            tick_elapsed = elapsed_reg;
        else if (step_sum > {1'b0, span_time_reg})
            tick_elapsed = loop_reg ? '0 : span_time_reg;
        else
            tick_elapsed = step_sum[SPAN_W-1:0];
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        current_next = current_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        t_next       = t_reg;
        e_next       = e_reg;
        pub_next     = pub_reg;
        pres_next    = pres_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg;
        div_start    = 1'b0;
        mul_load     = 1'b0;
        mul_a        = MUL_W'(t_reg);
        mul_b        = MUL_W'(t_reg);
        in_xfer      = s_tvalid && (state_reg == ST_IDLE);

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next   = s_tuser;
                    step_next = s_tdata;
                    if (s_tuser == OP_TICK)
                    begin
                        if (span_time_reg == '0)
                        begin
                            t_next     = UNIT_V;
                            state_next = ST_EASE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    else
                        state_next = ST_DONE;
                end
            end

            ST_DIV:
            begin
                if (div_st.done && !div_st.busy)
                begin
                    t_next     = div_quot;
                    state_next = ST_EASE;
                end
            end

            // curve product, or the ease factor itself (the progress, or unit) where no product is needed
            ST_EASE:
            begin
                case (ease_mode_reg)
                    EASE_LINEAR:
                    begin
                        e_next     = t_reg;
                        state_next = ST_FINAL;
                    end
                    EASE_QUAD_IN, EASE_QUAD_OUT:
                    begin
                        mul_load   = 1'b1;
                        state_next = ST_EASE_FIX;
                    end
                    EASE_QUAD_INOUT:
                    begin
                        mul_load = 1'b1;
                        if (t_low)
                            mul_a = MUL_W'(t_reg <<< 1);
                        else
                        begin
                            mul_a = MUL_W'(d_val);
                            mul_b = MUL_W'(d_val);
                        end
                        state_next = ST_EASE_FIX;
                    end
                    default:
                    begin
                        e_next     = UNIT_V;
                        state_next = ST_FINAL;
                    end
                endcase
            end

            // shape the product into the ease factor
            ST_EASE_FIX:
            begin
                case (ease_mode_reg)
                    EASE_QUAD_OUT:
                        e_next = sat_val((PROD_W'(t_reg) <<< 1) - PROD_W'(sq_val));
                    EASE_QUAD_INOUT:
                    begin
                        if (t_low)
                            e_next = sq_val;
                        else
                            e_next = sat_val(PROD_W'(UNIT_V) - PROD_W'(dbl_val));
                    end
                    default:
                        e_next = sq_val;
                endcase
                state_next = ST_FINAL;
            end

            // (to - from) * ease
            ST_FINAL:
            begin
                mul_load   = 1'b1;
                mul_a      = diff_val;
                mul_b      = MUL_W'(e_reg);
                state_next = ST_DONE;
            end

            // commit the item once the output register is free
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    pub_next = current_reg;
                    case (op_reg)
                        OP_TICK:
                        begin
                            current_next = sat_val(PROD_W'(from_val) + part_val);
                            elapsed_next = tick_elapsed;
                        end
                        OP_RESTART:
                        begin
                            current_next = from_val;
                            elapsed_next = '0;
                            pub_next     = from_val;
                        end
                        OP_STOP:
                            elapsed_next = span_time_reg;
                        default: ;
                    endcase
                    pres_next    = current_next;
                    fin_next     = (elapsed_next >= span_time_reg);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            current_reg <= '0;
            m_valid_reg <= 1'b0;
            pub_reg     <= '0;
            pres_reg    <= '0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            current_reg <= current_next;
            m_valid_reg <= m_valid_next;
            pub_reg     <= pub_next;
            pres_reg    <= pres_next;
            fin_reg     <= fin_next;
        end
    end

    // item payload and intermediate values
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        step_reg <= step_next;
        t_reg    <= t_next;
        e_reg    <= e_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {pres_reg, pub_reg};
    assign m_tuser  = fin_reg;

endmodule
`default_nettype wire
